@@ sv/sutbl_pkg.sv @@
package sutbl_pkg;

    // fixed widths of the word fields
    localparam int KIND_BITS   = 3;
    localparam int KEY_BITS    = 32;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = 6;
    localparam int COUNT_BITS  = 7;

    // defaults for the top level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_LOOKUP  = 3'd2,
        KIND_REPLACE = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOTFOUND = 2'd1,
        STATUS_DUP      = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DEL_SETUP,
        ST_DEL,
        ST_INS_SETUP,
        ST_INS,
        ST_FINISH
    } state_t;

    // result of the shared compare unit
    typedef struct packed {
        logic less;
        logic equal;
    } cmp_res_t;

endpackage

@@ sv/sorted_unique_value_table.sv @@
// lookup scans the stored entries from slot 0 until it meets one that is not below the key;
// delete then shifts the entries above the found slot down, insert shifts them up; replace
// scans twice (new value, then key) and, when the key is found and the new value is not
// stored, shifts down and then up. clear and unused kinds go straight to the response.
// throughput: one word at a time; a new word is taken once the last one has
// reached the response register. the single ram port pair sets the pace.
// reset (rst_n, async, low): table empty, no response pending; ram not cleared
module sorted_unique_value_table #(
    parameter int CAPACITY   = sutbl_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sutbl_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic [sutbl_pkg::KIND_BITS-1:0]        kind,
    input  logic signed [sutbl_pkg::KEY_BITS-1:0]  key,
    input  logic signed [sutbl_pkg::KEY_BITS-1:0]  new_value,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic [sutbl_pkg::STATUS_BITS-1:0]      status,
    output logic                                   found,
    output logic [sutbl_pkg::POS_BITS-1:0]         position,
    output logic [sutbl_pkg::COUNT_BITS-1:0]       entry_count
);

    import sutbl_pkg::*;

    // stored value width: low bits of the key fields, taken as signed
    localparam int VW = (VALUE_BITS < KEY_BITS) ? VALUE_BITS : KEY_BITS;
    // ram address width and counter width (counter must hold CAPACITY)
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // sequencer
    state_t state_reg, state_next;

    // latched request word
    kind_t                kind_reg;
    logic signed [VW-1:0] key_reg;
    logic signed [VW-1:0] nv_reg;

    // working registers
    logic          pass_reg, pass_next;       // replace: 0 scans new value, 1 scans key
    logic          dup_reg, dup_next;         // replace: new value already stored
    logic [CW-1:0] q_reg, q_next;             // replace: slot of new value in old table
    logic [CW-1:0] ptr_reg, ptr_next;         // scan index or shift destination
    logic [CW-1:0] ins_pos_reg, ins_pos_next; // where the new value lands
    logic [CW-1:0] count_reg, count_next;     // number of stored values
    logic signed [VW-1:0] ins_val_reg, ins_val_next;

    // result being built
    status_t       res_status_reg, res_status_next;
    logic          res_found_reg, res_found_next;
    logic [CW-1:0] res_pos_reg, res_pos_next;

    // response register
    logic                   rsp_valid_reg;
    status_t                status_reg;
    logic                   found_reg;
    logic [POS_BITS-1:0]    position_reg;
    logic [COUNT_BITS-1:0]  entry_count_reg;

    // ram port signals
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [VW-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic signed [VW-1:0] rd_data;

    // compare unit
    logic signed [VW-1:0] target;
    cmp_res_t             cmp_res;

    // decode helpers
    logic          req_fire;
    logic          rsp_load;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] repl_pos;
    logic          in_range;
    logic          scan_more;
    logic          hit;
    logic          full;
    logic          dn_more;
    logic          up_more;

    sutbl_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // first replace pass looks for the new value, every other scan for the key
    assign target = (kind_reg == KIND_REPLACE && !pass_reg) ? nv_reg : key_reg;

    sutbl_cmp #(
        .VW (VW)
    ) u_cmp (
        .a   (rd_data),
        .b   (target),
        .res (cmp_res)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_load  = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp_ready);

    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    // rd_data holds entry ptr_reg during a scan; entries past count never match
    assign in_range  = (ptr_reg < count_reg);
    assign scan_more = in_range && cmp_res.less;
    assign hit       = in_range && cmp_res.equal;
    assign full      = (count_reg == CAP_C);

    // delete moves entries down one slot, insert moves them up one slot
    assign dn_more = (ptr_inc < count_reg);
    assign up_more = (ptr_reg > ins_pos_reg);

    // replace: slot of the new value once the old key is gone
    assign repl_pos = (q_reg > ptr_reg) ? (q_reg - CW'(1)) : q_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (kind == KIND_CLEAR || kind > KIND_REPLACE)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!scan_more)
                begin
                    unique case (kind_reg)
                        KIND_INSERT:  state_next = (hit || full) ? ST_FINISH : ST_INS_SETUP;
                        KIND_DELETE:  state_next = hit ? ST_DEL_SETUP : ST_FINISH;
                        KIND_REPLACE:
                        begin
                            if (!pass_reg)
                            begin
                                state_next = ST_START;
                            end
                            else
                            begin
                                state_next = (!dup_reg && hit) ? ST_DEL_SETUP : ST_FINISH;
                            end
                        end
                        default:      state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DEL_SETUP:
            begin
                state_next = ST_DEL;
            end
            ST_DEL:
            begin
                if (!dn_more)
                begin
                    state_next = (kind_reg == KIND_REPLACE) ? ST_INS_SETUP : ST_FINISH;
                end
            end
            ST_INS_SETUP:
            begin
                state_next = ST_INS;
            end
            ST_INS:
            begin
                if (!up_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and working register updates
    always_comb
    begin
        pass_next       = pass_reg;
        dup_next        = dup_reg;
        q_next          = q_reg;
        ptr_next        = ptr_reg;
        ins_pos_next    = ins_pos_reg;
        ins_val_next    = ins_val_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        wr_en           = 1'b0;
        wr_addr         = AW'(ptr_reg);
        wr_data         = rd_data;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    pass_next       = 1'b0;
                    dup_next        = 1'b0;
                    res_status_next = STATUS_OK;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                    if (kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_START:
            begin
                // entry 0 is read this cycle
                ptr_next = '0;
            end
            ST_SCAN:
            begin
                if (scan_more)
                begin
                    ptr_next = ptr_inc;
                    rd_addr  = AW'(ptr_inc);
                end
                else
                begin
                    unique case (kind_reg)
                        KIND_INSERT:
                        begin
                            if (hit)
                            begin
                                res_status_next = STATUS_DUP;
                                res_found_next  = 1'b1;
                                res_pos_next    = ptr_reg;
                            end
                            else if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ins_pos_next = ptr_reg;
                                ins_val_next = key_reg;
                                res_pos_next = ptr_reg;
                            end
                        end
                        KIND_DELETE, KIND_LOOKUP:
                        begin
                            // delete keeps ptr_reg as the first slot to refill
                            if (hit)
                            begin
                                res_found_next = 1'b1;
                                res_pos_next   = ptr_reg;
                            end
                            else
                            begin
                                res_status_next = STATUS_NOTFOUND;
                            end
                        end
                        KIND_REPLACE:
                        begin
                            if (!pass_reg)
                            begin
                                q_next    = ptr_reg;
                                dup_next  = hit;
                                pass_next = 1'b1;
                            end
                            else if (dup_reg)
                            begin
                                res_status_next = STATUS_DUP;
                                res_found_next  = hit;
                                res_pos_next    = hit ? ptr_reg : '0;
                            end
                            else if (hit)
                            begin
                                res_found_next = 1'b1;
                                ins_pos_next   = repl_pos;
                                ins_val_next   = nv_reg;
                                res_pos_next   = repl_pos;
                            end
                            else
                            begin
                                res_status_next = STATUS_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_DEL_SETUP:
            begin
                rd_addr = AW'(ptr_inc);
            end
            ST_DEL:
            begin
                // rd_data holds entry ptr_reg + 1, it drops into ptr_reg
                if (dn_more)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(ptr_reg);
                    wr_data  = rd_data;
                    ptr_next = ptr_inc;
                    rd_addr  = AW'(ptr_reg + CW'(2));
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_INS_SETUP:
            begin
                rd_addr  = AW'(count_reg - CW'(1));
                ptr_next = count_reg;
            end
            ST_INS:
            begin
                // rd_data holds entry ptr_reg - 1, it moves up into ptr_reg
                if (up_more)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(ptr_reg);
                    wr_data  = rd_data;
                    ptr_next = ptr_dec;
                    rd_addr  = AW'(ptr_reg - CW'(2));
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(ins_pos_reg);
                    wr_data    = ins_val_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            ST_FINISH:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= kind_t'(kind);
            key_reg  <= key[VW-1:0];
            nv_reg   <= new_value[VW-1:0];
        end
        pass_reg       <= pass_next;
        dup_reg        <= dup_next;
        q_reg          <= q_next;
        ptr_reg        <= ptr_next;
        ins_pos_reg    <= ins_pos_next;
        ins_val_reg    <= ins_val_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        if (rsp_load)
        begin
            status_reg      <= res_status_reg;
            found_reg       <= res_found_reg;
            position_reg    <= POS_BITS'(res_pos_reg);
            entry_count_reg <= COUNT_BITS'(count_reg);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

endmodule

@@ sv/sutbl_ram.sv @@
module sutbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/sutbl_cmp.sv @@
module sutbl_cmp #(
    parameter int VW = 32
) (
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    output sutbl_pkg::cmp_res_t  res
);

    import sutbl_pkg::*;

    // two's complement signed compare of a stored entry against the search target
    always_comb
    begin
        res.less  = (a < b);
        res.equal = (a == b);
    end

endmodule

@@ sv/sutbl_checker.sv @@
module sutbl_checker #(
    parameter int CAPACITY = sutbl_pkg::CAPACITY_DEF
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_ready,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic [sutbl_pkg::STATUS_BITS-1:0]     status,
    input logic                                  found,
    input logic [sutbl_pkg::POS_BITS-1:0]        position,
    input logic [sutbl_pkg::COUNT_BITS-1:0]      entry_count
);

    import sutbl_pkg::*;

    // one word in flight: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another word is in flight");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found)
            && $stable(position) && $stable(entry_count))
        else $error("response changed while stalled");

    // a missing key reports no position
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_NOTFOUND |-> !found && position == '0)
        else $error("not-found response carries a hit");

    // full is only reported with the table at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_FULL |->
            !found && position == '0 && entry_count == COUNT_BITS'(CAPACITY))
        else $error("full response with table below capacity");

endmodule

bind sorted_unique_value_table sutbl_checker #(
    .CAPACITY (CAPACITY)
) u_sutbl_checker (.*);

@@ bench/tb_sorted_unique_value_table.sv @@
module tb_sorted_unique_value_table;

    import sutbl_pkg::*;

    // table size and clocking
    localparam int SLOTS        = CAPACITY_DEF;
    localparam int PERIOD       = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 1200;

    // worst word is a replace on a full table
    localparam int DRAIN_CYCLES = 300;

    // long receiver hold-off, started once this many responses have been seen
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [KEY_BITS-1:0] VAL_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [KEY_BITS-1:0] VAL_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

    // kinds above clear are decoded as no-ops
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = KIND_BITS'(KIND_CLEAR + 1);
    localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = '1;

    // one request word plus the pacing drawn for it
    typedef struct {
        logic [KIND_BITS-1:0]       kind;
        logic signed [KEY_BITS-1:0] key;
        logic signed [KEY_BITS-1:0] new_value;
        int unsigned                send_gap;
        int unsigned                recv_stall;
    } table_word_t;

    // predicted response word, with the request kept for reporting
    typedef struct {
        status_t                    status;
        logic                       found;
        logic [POS_BITS-1:0]        position;
        logic [COUNT_BITS-1:0]      entry_count;
        logic [KIND_BITS-1:0]       op_kind;
        logic signed [KEY_BITS-1:0] op_key;
        int unsigned                stall;
    } table_rsp_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    logic [KIND_BITS-1:0]       kind      = '0;
    logic signed [KEY_BITS-1:0] key       = '0;
    logic signed [KEY_BITS-1:0] new_value = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic [STATUS_BITS-1:0]     status;
    logic                       found;
    logic [POS_BITS-1:0]        position;
    logic [COUNT_BITS-1:0]      entry_count;

    // receiver stall that travels with the word on the request side
    int unsigned                word_stall = 0;
    logic                       hold_off   = 1'b0;

    // words waiting to be sent and responses still owed by the block
    table_word_t                word_q[$];
    table_rsp_t                 owed_rsp_q[$];

    // shadow copy of the sorted set
    logic signed [KEY_BITS-1:0] table_vals[SLOTS];
    int unsigned                table_count = 0;

    // stimulus shaping
    logic signed [KEY_BITS-1:0] key_pool[$];
    bit                         idle_on = 1'b1;

    table_word_t                drv_word;
    int unsigned                drv_idle = 0;
    table_rsp_t                 rsp_want;
    int unsigned                rsp_stall_cnt = 0;
    int                         rsp_seen = 0;
    int                         err_count = 0;

    sorted_unique_value_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .kind        (kind),
        .key         (key),
        .new_value   (new_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .found       (found),
        .position    (position),
        .entry_count (entry_count)
    );

    always
    begin
        #(PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // shadow set operations
    // ---------------------------------------------------------------

    // first slot whose value is not below v
    function automatic int unsigned lower_index(logic signed [KEY_BITS-1:0] v);
        int unsigned i = 0;
        while (i < table_count && table_vals[i] < v)
            i++;
        return i;
    endfunction

    function automatic bit locate(input logic signed [KEY_BITS-1:0] v,
                                  output int unsigned idx);
        idx = lower_index(v);
        return idx < table_count && table_vals[idx] == v;
    endfunction

    function automatic void drop_slot(int unsigned idx);
        for (int unsigned j = idx; j + 1 < table_count; j++)
            table_vals[j] = table_vals[j + 1];
        table_count--;
    endfunction

    function automatic int unsigned place_value(logic signed [KEY_BITS-1:0] v);
        int unsigned idx;
        idx = lower_index(v);
        for (int unsigned j = table_count; j > idx; j--)
            table_vals[j] = table_vals[j - 1];
        table_vals[idx] = v;
        table_count++;
        return idx;
    endfunction

    // applies one request to the shadow set and returns the response it owes
    function automatic table_rsp_t apply_table_op(logic [KIND_BITS-1:0] op,
                                                  logic signed [KEY_BITS-1:0] k,
                                                  logic signed [KEY_BITS-1:0] nv);
        table_rsp_t  r;
        int unsigned p;
        int unsigned q;
        r.status   = STATUS_OK;
        r.found    = 1'b0;
        r.position = '0;
        r.op_kind  = op;
        r.op_key   = k;
        r.stall    = 0;
        case (op)
            KIND_INSERT:
            begin
                // a stored key wins over a full table
                if (locate(k, p))
                begin
                    r.status   = STATUS_DUP;
                    r.found    = 1'b1;
                    r.position = p[POS_BITS-1:0];
                end
                else if (table_count >= SLOTS)
                    r.status = STATUS_FULL;
                else
                begin
                    p = place_value(k);
                    r.position = p[POS_BITS-1:0];
                end
            end
            KIND_DELETE:
            begin
                if (locate(k, p))
                begin
                    r.found    = 1'b1;
                    r.position = p[POS_BITS-1:0];
                    drop_slot(p);
                end
                else
                    r.status = STATUS_NOTFOUND;
            end
            KIND_LOOKUP:
            begin
                if (locate(k, p))
                begin
                    r.found    = 1'b1;
                    r.position = p[POS_BITS-1:0];
                end
                else
                    r.status = STATUS_NOTFOUND;
            end
            KIND_REPLACE:
            begin
                // a stored new value is checked before the old key
                if (locate(nv, q))
                begin
                    r.status = STATUS_DUP;
                    if (locate(k, p))
                    begin
                        r.found    = 1'b1;
                        r.position = p[POS_BITS-1:0];
                    end
                end
                else if (locate(k, p))
                begin
                    r.found = 1'b1;
                    drop_slot(p);
                    q = place_value(nv);
                    r.position = q[POS_BITS-1:0];
                end
                else
                    r.status = STATUS_NOTFOUND;
            end
            KIND_CLEAR:
                table_count = 0;
            default:
                ;
        endcase
        r.entry_count = table_count[COUNT_BITS-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    function automatic logic signed [KEY_BITS-1:0] extreme_value();
        case ($urandom_range(0, 5))
            0:       return VAL_MIN;
            1:       return VAL_MIN + 1;
            2:       return VAL_MAX;
            3:       return VAL_MAX - 1;
            4:       return '0;
            default: return '1;
        endcase
    endfunction

    // pool mixes full-range, near-zero and near-limit values
    function automatic void refresh_pool(int unsigned n);
        int v;
        key_pool.delete();
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    v = $urandom_range(0, 80);
                    key_pool.push_back(v - 40);
                end
                1:       key_pool.push_back(extreme_value());
                default: key_pool.push_back($urandom);
            endcase
        end
    endfunction

    // mostly pool hits so that lookups, deletes and duplicates land often
    function automatic logic signed [KEY_BITS-1:0] draw_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 90)
            return $urandom;
        else
            return extreme_value();
    endfunction

    function automatic void push_word(logic [KIND_BITS-1:0] op,
                                      logic signed [KEY_BITS-1:0] k,
                                      logic signed [KEY_BITS-1:0] nv);
        table_word_t w;
        w.kind       = op;
        w.key        = k;
        w.new_value  = nv;
        w.send_gap   = idle_on ? $urandom_range(0, 10) : 0;
        w.recv_stall = idle_on ? $urandom_range(0, 10) : 0;
        word_q.push_back(w);
    endfunction

    function automatic void push_random_op();
        int unsigned                r;
        logic signed [KEY_BITS-1:0] a;
        logic signed [KEY_BITS-1:0] b;
        r = $urandom_range(0, 99);
        a = draw_value();
        b = draw_value();
        if (r < 35)
            push_word(KIND_INSERT, a, $urandom);
        else if (r < 55)
            push_word(KIND_DELETE, a, $urandom);
        else if (r < 75)
            push_word(KIND_LOOKUP, a, $urandom);
        else if (r < 95)
            push_word(KIND_REPLACE, a, ($urandom_range(0, 19) == 0) ? a : b);
        else if (r < 97)
            push_word(KIND_CLEAR, a, b);
        else
            push_word(KIND_BITS'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), a, b);
    endfunction

    // ---------------------------------------------------------------
    // request driver: presents the next queued word once its gap has run out
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            kind       <= '0;
            key        <= '0;
            new_value  <= '0;
            word_stall <= 0;
            drv_idle   = 0;
        end
        else if (!req_valid || req_ready)
        begin
            // nothing held, so the current word (if any) is taken this edge
            if (word_q.size() != 0 && drv_idle >= word_q[0].send_gap)
            begin
                drv_word = word_q.pop_front();
                req_valid  <= 1'b1;
                kind       <= drv_word.kind;
                key        <= drv_word.key;
                new_value  <= drv_word.new_value;
                word_stall <= drv_word.recv_stall;
                drv_idle   = 0;
            end
            else
            begin
                req_valid <= 1'b0;
                if (word_q.size() != 0)
                    drv_idle++;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: predicts on each accepted request, checks each response word
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready     <= 1'b0;
            rsp_stall_cnt = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                rsp_want = apply_table_op(kind, key, new_value);
                rsp_want.stall = word_stall;
                owed_rsp_q.push_back(rsp_want);
            end

            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                rsp_stall_cnt = 0;
                if (owed_rsp_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected response:",
                                 " status %0d found %0d", status, found,
                                 " position %0d count %0d", position, entry_count);
                end
                else
                begin
                    rsp_want = owed_rsp_q.pop_front();
                    if (status !== rsp_want.status || found !== rsp_want.found ||
                        position !== rsp_want.position ||
                        entry_count !== rsp_want.entry_count)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("mismatch kind %0d key %0d:",
                                     rsp_want.op_kind, rsp_want.op_key,
                                     " expected %0d/%0d/%0d/%0d,",
                                     rsp_want.status, rsp_want.found,
                                     rsp_want.position, rsp_want.entry_count,
                                     " got %0d/%0d/%0d/%0d",
                                     status, found, position, entry_count);
                    end
                end
            end
            else if (rsp_valid)
                rsp_stall_cnt++;

            // stall counted only while a response is on offer
            if (hold_off)
                rsp_ready <= 1'b0;
            else if (owed_rsp_q.size() == 0)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= (rsp_stall_cnt >= owed_rsp_q[0].stall);
        end
    end

    // one long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (rsp_seen >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // hard limit on the run
    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        // directed words: empty table, extremes, duplicates at both ends,
        // every replace outcome, spare kinds, clear
        idle_on = 1'b1;
        push_word(KIND_LOOKUP, 5, $urandom);
        push_word(KIND_DELETE, 5, $urandom);
        push_word(KIND_INSERT, 0, $urandom);
        push_word(KIND_INSERT, VAL_MIN, $urandom);
        push_word(KIND_INSERT, VAL_MAX, $urandom);
        push_word(KIND_INSERT, VAL_MIN, $urandom);
        push_word(KIND_INSERT, VAL_MAX, $urandom);
        push_word(KIND_INSERT, -1, $urandom);
        push_word(KIND_LOOKUP, VAL_MIN, $urandom);
        push_word(KIND_LOOKUP, VAL_MAX, $urandom);
        push_word(KIND_LOOKUP, 7, $urandom);
        push_word(KIND_DELETE, 7, $urandom);
        push_word(KIND_REPLACE, 7, 9);
        push_word(KIND_REPLACE, 0, 0);
        push_word(KIND_REPLACE, 0, VAL_MAX);
        push_word(KIND_REPLACE, 7, VAL_MAX);
        push_word(KIND_REPLACE, VAL_MIN, 100);
        push_word(KIND_REPLACE, VAL_MAX, VAL_MIN);
        push_word(KIND_DELETE, -1, $urandom);
        push_word(KIND_SPARE_LO, $urandom, $urandom);
        push_word(KIND_SPARE_HI, $urandom, $urandom);
        push_word(KIND_CLEAR, $urandom, $urandom);
        push_word(KIND_LOOKUP, 0, $urandom);
        push_word(KIND_INSERT, 12345, $urandom);
        push_word(KIND_DELETE, 12345, $urandom);

        // random segments: fills that drive the table to full, and mixed
        // traffic over pools of varying size
        while (word_q.size() < RANDOM_WORDS + 25)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
            begin
                push_word(KIND_CLEAR, $urandom, $urandom);
                refresh_pool(SLOTS + 8);
                foreach (key_pool[i])
                begin
                    push_word(KIND_INSERT, key_pool[i], $urandom);
                    if ($urandom_range(0, 4) == 0)
                        push_random_op();
                end
            end
            else
            begin
                refresh_pool($urandom_range(4, 96));
                repeat ($urandom_range(60, 160))
                    push_random_op();
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() != 0 || req_valid || owed_rsp_q.size() != 0)
            @(negedge clk);
        // catch any stray word the block might still emit
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
